// ===== rtl/skf_pkg.sv =====
// Shared constants for the scalar Kalman filter: default widths,
// configuration register indexes and their reset values, item kind codes.
// No dependencies.
`default_nettype none

package skf_pkg;

  // Default data path shape (signed fixed point, Q16.16)
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed field widths of the ports
  localparam int SAMPLE_W = 32;
  localparam int VAR_W    = 31;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd3;

  // Configuration reset values
  localparam logic [SAMPLE_W-1:0] INIT_EST_RST   = 32'd0;
  localparam logic [VAR_W-1:0]    INIT_ERR_RST   = 31'd65536;
  localparam logic [VAR_W-1:0]    PROC_NOISE_RST = 31'd655;
  localparam logic [VAR_W-1:0]    MEAS_NOISE_RST = 31'd6554;

  // Item kinds
  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_REINIT  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/scalar_kalman_filter.sv =====
// Scalar Kalman filter, bit-serial divider and shift-add multipliers; uses skf_pkg.
// Measurement: the item passes the prediction state, the restoring divider
// (FRAC_BITS+1 steps), the shift-add multiply (FRAC_BITS+1 steps) and the output
// state; in_stall stays high until the result is registered, so the next item waits.
// Reinitialize: estimate and variance load from the registers, then the output state.
// Synchronous active-low reset clears estimate and variance, loads register defaults.
`default_nettype none

module scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic [SAMPLE_W-1:0]   in_sample,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SAMPLE_W-1:0]        out_filtered_value,
  output logic [VAR_W-1:0]           out_variance_out,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [SAMPLE_W-1:0]   cfg_data
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = $clog2(F + 1);
  // Compare width that holds both the 32-bit fields and the data path
  localparam int XW = ((W > SAMPLE_W) ? W : SAMPLE_W) + 1;

  localparam logic [XW-1:0] SMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [XW-1:0] SMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [XW-1:0] OMAX_X = {{(XW-VAR_W){1'b0}}, {VAR_W{1'b1}}};
  localparam logic [XW-1:0] OMIN_X = {{(XW-VAR_W){1'b1}}, {VAR_W{1'b0}}};
  localparam logic [F:0]    ONE_Q  = {1'b1, {F{1'b0}}};
  localparam logic [CW-1:0] LAST   = CW'(F);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PRED = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  // Clamp a signed 32-bit field to the data path range
  function automatic logic [W-1:0] sat_s(input logic [SAMPLE_W-1:0] v);
    logic [XW-1:0] x;
    x = {{(XW-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    if ($signed(x) > $signed(SMAX_X))      sat_s = SMAX_X[W-1:0];
    else if ($signed(x) < $signed(SMIN_X)) sat_s = SMIN_X[W-1:0];
    else                                   sat_s = x[W-1:0];
  endfunction

  // Clamp an unsigned 31-bit field to the variance range
  function automatic logic [W-2:0] sat_v(input logic [VAR_W-1:0] v);
    logic [XW-1:0] x;
    x = {{(XW-VAR_W){1'b0}}, v};
    if (x > SMAX_X) sat_v = SMAX_X[W-2:0];
    else            sat_v = x[W-2:0];
  endfunction

  // Configuration registers
  logic [SAMPLE_W-1:0] init_est_r;
  logic [VAR_W-1:0]    init_err_r, proc_noise_r, meas_noise_r;

  // Filter state
  logic [W-1:0] est_r, est_nxt;
  logic [W-2:0] var_r, var_nxt;

  // Control
  state_t       state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic         out_valid_r, out_valid_nxt;

  // Working registers
  logic [W-1:0]  z_r, z_nxt;
  logic [W-2:0]  ppred_r, ppred_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic          dz_r, dz_nxt;
  logic          neg_r, neg_nxt;
  logic [W:0]    mag_r, mag_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [F:0]    quo_r, quo_nxt;
  logic [F:0]    kmul_r, kmul_nxt;
  logic [F:0]    vmul_r, vmul_nxt;
  logic [W:0]    acc_e_r, acc_e_nxt;
  logic [W-1:0]  acc_v_r, acc_v_nxt;
  logic [SAMPLE_W-1:0] out_est_r, out_est_nxt;
  logic [VAR_W-1:0]    out_var_r, out_var_nxt;

  // Combinational helpers
  logic [W-1:0]  psum, rsat_ext;
  logic [W-2:0]  ppred_c, qsat, rsat;
  logic [W-1:0]  den_c;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rsub;
  logic [F:0]    quo_step, k_fin;
  logic [W:0]    sum_e, est_new;
  logic [W-1:0]  sum_v;
  logic [XW-1:0] est_x, var_x;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_filtered_value = out_est_r;
  assign out_variance_out   = out_var_r;

  // Prediction: variance plus process noise, gain divisor, innovation
  always_comb begin
    qsat     = sat_v(proc_noise_r);
    rsat     = sat_v(meas_noise_r);
    psum     = {1'b0, var_r} + {1'b0, qsat};
    ppred_c  = psum[W-1] ? {(W-1){1'b1}} : psum[W-2:0];
    rsat_ext = {1'b0, rsat};
    den_c    = {1'b0, ppred_c} + rsat_ext;
    diff     = {z_r[W-1], z_r} - {est_r[W-1], est_r};
  end

  // One restoring division step
  always_comb begin
    ge       = (rem_r >= {1'b0, den_r});
    rsub     = ge ? (rem_r[W-1:0] - den_r) : rem_r[W-1:0];
    quo_step = {quo_r[F-1:0], ge};
    k_fin    = dz_r ? '0 : quo_step;
  end

  // One shift-add multiply step for both products
  always_comb begin
    sum_e   = acc_e_r + (kmul_r[0] ? mag_r : '0);
    sum_v   = acc_v_r + (vmul_r[0] ? {1'b0, ppred_r} : '0);
    est_new = neg_r ? ({est_r[W-1], est_r} - sum_e) : ({est_r[W-1], est_r} + sum_e);
  end

  // Widened estimate and variance for the output clamps to the 32-bit signed and 31-bit unsigned fields
  always_comb begin
    est_x = {{(XW-W){est_r[W-1]}}, est_r};
    var_x = {{(XW-W+1){1'b0}}, var_r};
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    est_nxt       = est_r;
    var_nxt       = var_r;
    z_nxt         = z_r;
    ppred_nxt     = ppred_r;
    den_nxt       = den_r;
    dz_nxt        = dz_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    kmul_nxt      = kmul_r;
    vmul_nxt      = vmul_r;
    acc_e_nxt     = acc_e_r;
    acc_v_nxt     = acc_v_r;
    out_est_nxt   = out_est_r;
    out_var_nxt   = out_var_r;

    // drop the result once taken
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_REINIT) begin
            est_nxt   = sat_s(init_est_r);
            var_nxt   = sat_v(init_err_r);
            state_nxt = ST_OUT;
          end else begin
            z_nxt     = sat_s(in_sample);
            state_nxt = ST_PRED;
          end
        end
      end
      ST_PRED: begin
        ppred_nxt = ppred_c;
        den_nxt   = den_c;
        dz_nxt    = (den_c == '0);
        neg_nxt   = diff[W];
        mag_nxt   = diff[W] ? ('0 - diff) : diff;
        rem_nxt   = {2'b00, ppred_c};
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = {rsub, 1'b0};
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          kmul_nxt  = k_fin;
          vmul_nxt  = ONE_Q - k_fin;
          acc_e_nxt = '0;
          acc_v_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_r != LAST) begin
          // accumulate and shift out the fraction bit
          acc_e_nxt = {1'b0, sum_e[W:1]};
          acc_v_nxt = {1'b0, sum_v[W-1:1]};
          kmul_nxt  = {1'b0, kmul_r[F:1]};
          vmul_nxt  = {1'b0, vmul_r[F:1]};
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          // top gain bit: no shift, product is already scaled down
          est_nxt   = est_new[W-1:0];
          var_nxt   = sum_v[W-2:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          if ($signed(est_x) > $signed(OMAX_X))      out_est_nxt = {1'b0, {VAR_W{1'b1}}};
          else if ($signed(est_x) < $signed(OMIN_X)) out_est_nxt = {1'b1, {VAR_W{1'b0}}};
          else                                       out_est_nxt = est_x[SAMPLE_W-1:0];
          out_var_nxt   = (var_x > OMAX_X) ? {VAR_W{1'b1}} : var_x[VAR_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      est_r        <= '0;
      var_r        <= '0;
      init_est_r   <= INIT_EST_RST;
      init_err_r   <= INIT_ERR_RST;
      proc_noise_r <= PROC_NOISE_RST;
      meas_noise_r <= MEAS_NOISE_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INIT_EST:   init_est_r   <= cfg_data;
          CFG_INIT_ERR:   init_err_r   <= cfg_data[VAR_W-1:0];
          CFG_PROC_NOISE: proc_noise_r <= cfg_data[VAR_W-1:0];
          CFG_MEAS_NOISE: meas_noise_r <= cfg_data[VAR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    z_r       <= z_nxt;
    ppred_r   <= ppred_nxt;
    den_r     <= den_nxt;
    dz_r      <= dz_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    kmul_r    <= kmul_nxt;
    vmul_r    <= vmul_nxt;
    acc_e_r   <= acc_e_nxt;
    acc_v_r   <= acc_v_nxt;
    out_est_r <= out_est_nxt;
    out_var_r <= out_var_nxt;
  end

endmodule

`default_nettype wire
